@@ src/assert_macros.svh @@
// Assertion macros used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define PLU_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define PLU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/plu_pkg.sv @@
// Shared types, constants and step functions of the Phong lighting unit.
`timescale 1ns / 1ps

package plu_pkg;

    localparam int SQRT_STEPS = 2;
    localparam int SQRT_STAGES = 32 / SQRT_STEPS;
    localparam int DIV_STEPS = 2;
    localparam int DIV_STAGES = 16 / DIV_STEPS;

    localparam logic signed [15:0] LIGHT_X_RESET = 16'sd9459;
    localparam logic signed [15:0] LIGHT_Y_RESET = 16'sd9459;
    localparam logic signed [15:0] LIGHT_Z_RESET = -16'sd9459;

    localparam logic [32:0] AMBIENT_Q32 = 33'd214748365;
    localparam logic signed [17:0] DIFFUSE_Q16 = 18'sd45875;
    localparam int SPEC_SHIFT = 15;
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [44:0] HALF_Q32 = 45'h0_8000_0000;
    localparam int R_SCALE_SHIFT = 17;
    localparam int L_SHIFT = 28;

    typedef enum logic [1:0] {
        REG_LIGHT_X = 2'd0,
        REG_LIGHT_Y = 2'd1,
        REG_LIGHT_Z = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vec16_t;

    typedef struct packed {
        logic               valid;
        logic [63:0]        nl_sq;
        logic [63:0]        rr;
        logic signed [32:0] d;
        logic signed [31:0] rz;
    } geom_t;

    typedef struct packed {
        logic               valid;
        logic [31:0]        nl;
        logic [31:0]        rlen;
        logic signed [32:0] d;
        logic signed [31:0] rz;
    } len_t;

    typedef struct packed {
        logic               valid;
        logic signed [17:0] diff;
        logic signed [17:0] spec;
    } cos_t;

    typedef struct packed {
        logic        valid;
        logic [11:0] red;
        logic [11:0] green;
        logic [11:0] blue;
    } color_t;

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_st_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [15:0] q;
    } div_st_t;

    // One digit of the floor square root, two radicand bits per digit.
    function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
        sqrt_st_t    o;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        rem_sh = {s.rem, s.rad[63:62]};
        trial = {2'b00, s.root, 2'b01};
        o.rad = {s.rad[61:0], 2'b00};
        if (rem_sh >= trial)
        begin
            o.rem = 34'(rem_sh - trial);
            o.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            o.rem = rem_sh[33:0];
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    // One quotient bit of a restoring divide; rem stays below den if it starts below den.
    function automatic div_st_t div_step(input div_st_t s, input logic [31:0] den);
        div_st_t     o;
        logic [32:0] rem_sh;
        rem_sh = {s.rem, 1'b0};
        if (rem_sh >= {1'b0, den})
        begin
            o.rem = 32'(rem_sh - {1'b0, den});
            o.q = {s.q[14:0], 1'b1};
        end
        else
        begin
            o.rem = rem_sh[31:0];
            o.q = {s.q[14:0], 1'b0};
        end
        return o;
    endfunction

endpackage

@@ src/plu_front.sv @@
// Vector front end: dot products, squared lengths and reflection vector.
`timescale 1ns / 1ps

module plu_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  plu_pkg::vec16_t n,
    input  plu_pkg::vec16_t light,
    output plu_pkg::geom_t  geom
);

    logic [5:0] v_reg;

    logic signed [15:0] n_a [3];
    logic signed [15:0] l_a [3];

    logic signed [31:0] pd1_reg  [3];
    logic signed [31:0] nsq1_reg [3];
    logic signed [31:0] lsq1_reg [3];
    logic signed [15:0] n1_reg   [3];

    logic signed [32:0] d2_reg;
    logic [31:0]        nn2_reg;
    logic [31:0]        ll2_reg;
    logic signed [15:0] n2_reg [3];

    logic [63:0]        nlsq3_reg;
    logic signed [48:0] dn3_reg [3];
    logic signed [32:0] d3_reg;

    logic signed [49:0] raw4 [3];
    logic [49:0]        mag4 [3];
    logic [49:0]        sh4  [3];
    logic signed [31:0] r4_reg [3];
    logic [63:0]        nlsq4_reg;
    logic signed [32:0] d4_reg;

    logic [30:0]        rmag5 [3];
    logic [61:0]        sq5_reg [3];
    logic signed [31:0] rz5_reg;
    logic [63:0]        nlsq5_reg;
    logic signed [32:0] d5_reg;

    logic [63:0]        rr6_reg;
    logic signed [31:0] rz6_reg;
    logic [63:0]        nlsq6_reg;
    logic signed [32:0] d6_reg;

    assign n_a[0] = n.x;
    assign n_a[1] = n.y;
    assign n_a[2] = n.z;
    assign l_a[0] = light.x;
    assign l_a[1] = light.y;
    assign l_a[2] = light.z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[4:0], in_valid};
    end

    // r = 2dN - L scaled from Q42 to Q25, truncating the magnitude
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            raw4[k] = (50'(dn3_reg[k]) <<< 1) - (50'(l_a[k]) <<< plu_pkg::L_SHIFT);
            mag4[k] = raw4[k][49] ? 50'(-raw4[k]) : 50'(raw4[k]);
            sh4[k] = mag4[k] >> plu_pkg::R_SCALE_SHIFT;
        end
        for (int k = 0; k < 3; k++)
        begin
            rmag5[k] = r4_reg[k][31] ? 31'(-r4_reg[k]) : 31'(r4_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pd1_reg[k] <= l_a[k] * n_a[k];
                nsq1_reg[k] <= n_a[k] * n_a[k];
                lsq1_reg[k] <= l_a[k] * l_a[k];
                n1_reg[k] <= n_a[k];
            end

            d2_reg <= 33'(pd1_reg[0]) + 33'(pd1_reg[1]) + 33'(pd1_reg[2]);
            nn2_reg <= $unsigned(nsq1_reg[0]) + $unsigned(nsq1_reg[1])
                       + $unsigned(nsq1_reg[2]);
            ll2_reg <= $unsigned(lsq1_reg[0]) + $unsigned(lsq1_reg[1])
                       + $unsigned(lsq1_reg[2]);
            for (int k = 0; k < 3; k++)
                n2_reg[k] <= n1_reg[k];

            nlsq3_reg <= 64'(nn2_reg) * 64'(ll2_reg);
            for (int k = 0; k < 3; k++)
                dn3_reg[k] <= d2_reg * n2_reg[k];
            d3_reg <= d2_reg;

            for (int k = 0; k < 3; k++)
                r4_reg[k] <= raw4[k][49] ? -32'(sh4[k]) : 32'(sh4[k]);
            nlsq4_reg <= nlsq3_reg;
            d4_reg <= d3_reg;

            for (int k = 0; k < 3; k++)
                sq5_reg[k] <= 62'(rmag5[k]) * 62'(rmag5[k]);
            rz5_reg <= r4_reg[2];
            nlsq5_reg <= nlsq4_reg;
            d5_reg <= d4_reg;

            rr6_reg <= 64'(sq5_reg[0]) + 64'(sq5_reg[1]) + 64'(sq5_reg[2]);
            rz6_reg <= rz5_reg;
            nlsq6_reg <= nlsq5_reg;
            d6_reg <= d5_reg;
        end
    end

    assign geom.valid = v_reg[5];
    assign geom.nl_sq = nlsq6_reg;
    assign geom.rr = rr6_reg;
    assign geom.d = d6_reg;
    assign geom.rz = rz6_reg;

endmodule

@@ src/plu_norm.sv @@
// Two pipelined floor square roots: |N||L| and |r|.
`timescale 1ns / 1ps

module plu_norm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  plu_pkg::geom_t geom,
    output plu_pkg::len_t  len
);

    localparam int NS = plu_pkg::SQRT_STAGES;

    logic [NS-1:0] v_reg;

    plu_pkg::sqrt_st_t a_reg  [NS];
    plu_pkg::sqrt_st_t b_reg  [NS];
    plu_pkg::sqrt_st_t a_next [NS];
    plu_pkg::sqrt_st_t b_next [NS];
    logic signed [32:0] d_reg  [NS];
    logic signed [31:0] rz_reg [NS];

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (k == 0)
            begin
                a_next[k] = '{rad: geom.nl_sq, rem: '0, root: '0};
                b_next[k] = '{rad: geom.rr, rem: '0, root: '0};
            end
            else
            begin
                a_next[k] = a_reg[k-1];
                b_next[k] = b_reg[k-1];
            end
            for (int j = 0; j < plu_pkg::SQRT_STEPS; j++)
            begin
                a_next[k] = plu_pkg::sqrt_step(a_next[k]);
                b_next[k] = plu_pkg::sqrt_step(b_next[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NS-2:0], geom.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NS; k++)
            begin
                a_reg[k] <= a_next[k];
                b_reg[k] <= b_next[k];
                d_reg[k] <= (k == 0) ? geom.d : d_reg[k-1];
                rz_reg[k] <= (k == 0) ? geom.rz : rz_reg[k-1];
            end
        end
    end

    assign len.valid = v_reg[NS-1];
    assign len.nl = a_reg[NS-1].root;
    assign len.rlen = b_reg[NS-1].root;
    assign len.d = d_reg[NS-1];
    assign len.rz = rz_reg[NS-1];

endmodule

@@ src/plu_cos.sv @@
// Pipelined cosine ratios |num|*2^16/den for the diffuse and specular terms.
`timescale 1ns / 1ps

module plu_cos (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  plu_pkg::len_t len,
    output plu_pkg::cos_t cosv
);

    localparam int NS = plu_pkg::DIV_STAGES + 1;

    logic [NS-1:0] v_reg;

    // channel 0: diffuse, channel 1: specular
    logic [31:0] mag_in [2];
    logic [31:0] den_in [2];
    logic        neg_in [2];

    plu_pkg::div_st_t st_reg   [2][NS];
    plu_pkg::div_st_t st_next  [2][NS];
    logic [31:0]      den_reg  [2][NS];
    logic             neg_reg  [2][NS];
    logic             sat_reg  [2][NS];
    logic             zero_reg [2][NS];

    logic [16:0] mag_out [2];
    logic signed [17:0] cos_out [2];

    always_comb
    begin
        mag_in[0] = len.d[32] ? 32'(-len.d) : 32'(len.d);
        den_in[0] = len.nl;
        neg_in[0] = len.d[32];
        // numerator is -rz
        mag_in[1] = len.rz[31] ? 32'(-len.rz) : 32'(len.rz);
        den_in[1] = len.rlen;
        neg_in[1] = !len.rz[31] && (len.rz != '0);

        for (int c = 0; c < 2; c++)
        begin
            st_next[c][0].rem = mag_in[c];
            st_next[c][0].q = '0;
            for (int k = 1; k < NS; k++)
            begin
                st_next[c][k] = st_reg[c][k-1];
                for (int j = 0; j < plu_pkg::DIV_STEPS; j++)
                    st_next[c][k] = plu_pkg::div_step(st_next[c][k], den_reg[c][k-1]);
            end
        end

        for (int c = 0; c < 2; c++)
        begin
            if (zero_reg[c][NS-1])
                mag_out[c] = '0;
            else if (sat_reg[c][NS-1])
                mag_out[c] = plu_pkg::ONE_Q16;
            else
                mag_out[c] = {1'b0, st_reg[c][NS-1].q};
            cos_out[c] = neg_reg[c][NS-1] ? -18'(mag_out[c]) : 18'(mag_out[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NS-2:0], len.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 2; c++)
            begin
                for (int k = 0; k < NS; k++)
                begin
                    st_reg[c][k] <= st_next[c][k];
                    if (k == 0)
                    begin
                        den_reg[c][k] <= den_in[c];
                        neg_reg[c][k] <= neg_in[c];
                        // a ratio at or above one saturates
                        sat_reg[c][k] <= (mag_in[c] >= den_in[c]);
                        zero_reg[c][k] <= (den_in[c] == '0);
                    end
                    else
                    begin
                        den_reg[c][k] <= den_reg[c][k-1];
                        neg_reg[c][k] <= neg_reg[c][k-1];
                        sat_reg[c][k] <= sat_reg[c][k-1];
                        zero_reg[c][k] <= zero_reg[c][k-1];
                    end
                end
            end
        end
    end

    assign cosv.valid = v_reg[NS-1];
    assign cosv.diff = cos_out[0];
    assign cosv.spec = cos_out[1];

endmodule

@@ src/plu_shade.sv @@
// Specular fifth power, channel sums, saturation and 12-bit scaling.
`timescale 1ns / 1ps

module plu_shade (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  plu_pkg::cos_t   cosv,
    output plu_pkg::color_t color
);

    logic [4:0] v_reg;

    logic [16:0]        a_in;
    logic [33:0]        sq_a;
    logic [33:0]        sq_b;
    logic [33:0]        prod_c;
    logic [16:0]        a5_c;

    logic [16:0]        aA_reg;
    logic [16:0]        a2A_reg;
    logic               negA_reg;
    logic signed [17:0] diffA_reg;

    logic [16:0]        aB_reg;
    logic [16:0]        a4B_reg;
    logic               negB_reg;
    logic signed [17:0] diffB_reg;

    logic signed [17:0] s5C_reg;
    logic signed [17:0] diffC_reg;

    logic signed [35:0] diff_term;
    logic signed [35:0] spec_term;
    logic signed [35:0] red_sum;
    logic signed [35:0] gb_sum;
    logic [32:0]        red_clamp;
    logic [32:0]        gb_clamp;

    logic [32:0]        redD_reg;
    logic [32:0]        gbD_reg;

    logic [44:0]        red_scaled;
    logic [44:0]        gb_scaled;

    logic [11:0]        redE_reg;
    logic [11:0]        gbE_reg;

    function automatic logic signed [35:0] DIFFUSE_TERM(input logic signed [17:0] c);
        logic signed [35:0] p;
        p = plu_pkg::DIFFUSE_Q16 * c;
        return p;
    endfunction

    always_comb
    begin
        a_in = cosv.spec[17] ? 17'(-cosv.spec) : 17'(cosv.spec);
        sq_a = 34'(a_in) * 34'(a_in);
        sq_b = 34'(a2A_reg) * 34'(a2A_reg);
        prod_c = 34'(a4B_reg) * 34'(aB_reg);
        a5_c = 17'(prod_c >> 16);

        diff_term = DIFFUSE_TERM(diffC_reg);
        spec_term = 36'(s5C_reg) <<< plu_pkg::SPEC_SHIFT;
        red_sum = $signed({3'b000, plu_pkg::AMBIENT_Q32}) + diff_term + spec_term;
        gb_sum = $signed({3'b000, plu_pkg::AMBIENT_Q32}) + spec_term;

        if (red_sum[35])
            red_clamp = '0;
        else if (red_sum > $signed({3'b000, plu_pkg::ONE_Q32}))
            red_clamp = plu_pkg::ONE_Q32;
        else
            red_clamp = red_sum[32:0];

        if (gb_sum[35])
            gb_clamp = '0;
        else if (gb_sum > $signed({3'b000, plu_pkg::ONE_Q32}))
            gb_clamp = plu_pkg::ONE_Q32;
        else
            gb_clamp = gb_sum[32:0];

        // v * 4095 rounded half up, then the top bits
        red_scaled = {redD_reg, 12'd0} - 45'(redD_reg) + plu_pkg::HALF_Q32;
        gb_scaled = {gbD_reg, 12'd0} - 45'(gbD_reg) + plu_pkg::HALF_Q32;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], cosv.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aA_reg <= a_in;
            a2A_reg <= 17'(sq_a >> 16);
            negA_reg <= cosv.spec[17];
            diffA_reg <= cosv.diff;

            aB_reg <= aA_reg;
            a4B_reg <= 17'(sq_b >> 16);
            negB_reg <= negA_reg;
            diffB_reg <= diffA_reg;

            s5C_reg <= negB_reg ? -18'(a5_c) : 18'(a5_c);
            diffC_reg <= diffB_reg;

            redD_reg <= red_clamp;
            gbD_reg <= gb_clamp;

            redE_reg <= red_scaled[43:32];
            gbE_reg <= gb_scaled[43:32];
        end
    end

    assign color.valid = v_reg[4];
    assign color.red = redE_reg;
    assign color.green = gbE_reg;
    assign color.blue = gbE_reg;

endmodule

@@ src/phong_lighting_unit_core.sv @@
// A normal passes 36 pipeline registers and then the output register before its color
// can be taken. Throughput: one normal per cycle while normal_stall is low;
// the square roots and divides are fully pipelined.
// A two-entry output buffer (output register plus skid entry) holds results under stall.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the default light.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module phong_lighting_unit_core (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               normal_valid,
    output logic               normal_stall,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,

    output logic               color_valid,
    input  logic               color_stall,
    output logic [11:0]        red,
    output logic [11:0]        green,
    output logic [11:0]        blue
);

    logic signed [15:0] light_x_reg;
    logic signed [15:0] light_y_reg;
    logic signed [15:0] light_z_reg;

    plu_pkg::cfg_idx_t cfg_idx;
    logic              cfg_wr;

    logic              en;
    logic              in_take;
    plu_pkg::vec16_t   n_vec;
    plu_pkg::vec16_t   l_vec;
    plu_pkg::geom_t    geom;
    plu_pkg::len_t     len;
    plu_pkg::cos_t     cosv;
    plu_pkg::color_t   shade;

    plu_pkg::color_t   out_reg;
    plu_pkg::color_t   out_next;
    plu_pkg::color_t   skid_reg;
    plu_pkg::color_t   skid_next;
    logic              out_take;

    // configuration port
    assign pready = 1'b1;
    assign cfg_idx = plu_pkg::cfg_idx_t'(paddr[3:2]);
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx)
            plu_pkg::REG_LIGHT_X: prdata = {16'd0, $unsigned(light_x_reg)};
            plu_pkg::REG_LIGHT_Y: prdata = {16'd0, $unsigned(light_y_reg)};
            plu_pkg::REG_LIGHT_Z: prdata = {16'd0, $unsigned(light_z_reg)};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= plu_pkg::LIGHT_X_RESET;
            light_y_reg <= plu_pkg::LIGHT_Y_RESET;
            light_z_reg <= plu_pkg::LIGHT_Z_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                plu_pkg::REG_LIGHT_X: light_x_reg <= $signed(pwdata[15:0]);
                plu_pkg::REG_LIGHT_Y: light_y_reg <= $signed(pwdata[15:0]);
                plu_pkg::REG_LIGHT_Z: light_z_reg <= $signed(pwdata[15:0]);
                default:              ;
            endcase
        end
    end

    // pipeline moves unless the skid entry is holding a result
    assign en = !skid_reg.valid;
    assign normal_stall = skid_reg.valid;
    assign in_take = normal_valid && !normal_stall;

    assign n_vec = '{x: normal_x, y: normal_y, z: normal_z};
    assign l_vec = '{x: light_x_reg, y: light_y_reg, z: light_z_reg};

    plu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_take),
        .n        (n_vec),
        .light    (l_vec),
        .geom     (geom)
    );

    plu_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .geom  (geom),
        .len   (len)
    );

    plu_cos u_cos (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .len   (len),
        .cosv  (cosv)
    );

    plu_shade u_shade (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .cosv  (cosv),
        .color (shade)
    );

    // output register with skid entry
    assign out_take = out_reg.valid && !color_stall;

    always_comb
    begin
        out_next = out_reg;
        skid_next = skid_reg;
        if (skid_reg.valid)
        begin
            if (out_take || !out_reg.valid)
            begin
                out_next = skid_reg;
                skid_next.valid = 1'b0;
            end
        end
        else if (shade.valid)
        begin
            if (out_take || !out_reg.valid)
                out_next = shade;
            else
                skid_next = shade;
        end
        else if (out_take)
        begin
            out_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
            skid_reg <= '0;
        end
        else
        begin
            out_reg <= out_next;
            skid_reg <= skid_next;
        end
    end

    assign color_valid = out_reg.valid;
    assign red = out_reg.red;
    assign green = out_reg.green;
    assign blue = out_reg.blue;

    `PLU_ASSERT_IMPLY(a_skid_needs_out, skid_reg.valid, out_reg.valid,
        "skid entry full while output register empty")
    `PLU_ASSERT_NEXT(a_skid_holds, skid_reg.valid && color_stall, skid_reg.valid,
        "skid entry dropped while output stalled")
    `PLU_ASSERT_NEXT(a_overflow_to_skid, en && shade.valid && out_reg.valid && color_stall,
        skid_reg.valid, "pipeline result lost under stall")
    `PLU_ASSERT_IMPLY(a_green_blue, color_valid, green == blue,
        "green and blue channels differ")

endmodule

@@ test/phong_lighting_unit_core_tb.sv @@
// Self-checking testbench for the Phong lighting unit core.
`timescale 1ns / 1ps

module phong_lighting_unit_core_tb;

    localparam int LATENCY = 37;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [11:0] red;
        logic [11:0] green;
        logic [11:0] blue;
    } rgb_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               normal_valid = 1'b0;
    logic               normal_stall;
    logic signed [15:0] normal_x = '0;
    logic signed [15:0] normal_y = '0;
    logic signed [15:0] normal_z = '0;
    logic               color_valid;
    logic               color_stall = 1'b0;
    logic [11:0]        red;
    logic [11:0]        green;
    logic [11:0]        blue;

    logic signed [15:0] light_x = plu_pkg::LIGHT_X_RESET;
    logic signed [15:0] light_y = plu_pkg::LIGHT_Y_RESET;
    logic signed [15:0] light_z = plu_pkg::LIGHT_Z_RESET;

    rgb_t   expected_colors[$];
    int     mismatches = 0;
    longint cycles = 0;
    int     hold_off = 0;

    phong_lighting_unit_core dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[phong_lighting_unit_core] ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint cosine_q16(input longint num, input logic [63:0] den);
        logic [63:0] mag;
        if (den == 0)
            return 0;
        mag = (num < 0) ? -num : num;
        mag = (mag << 16) / den;
        if (mag > 65536)
            mag = 65536;
        return (num < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint reflect_q25(input longint v);
        logic [63:0] mag;
        mag = (v < 0) ? -v : v;
        mag >>= plu_pkg::R_SCALE_SHIFT;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [11:0] channel12(input longint v);
        logic [63:0] u;
        if (v < 0)
            v = 0;
        if (v > (longint'(1) << 32))
            v = longint'(1) << 32;
        u = v;
        return 12'((u * 4095 + (64'd1 << 31)) >> 32);
    endfunction

    function automatic rgb_t shade(input logic signed [15:0] nx16,
                                   input logic signed [15:0] ny16,
                                   input logic signed [15:0] nz16);
        longint nx, ny, nz, lx, ly, lz, d, rx, ry, rz, diff, spec, s5, r, gb;
        logic [63:0] nn, ll, nl, rlen, a, a2, a4;
        rgb_t c;
        nx = nx16; ny = ny16; nz = nz16;
        lx = light_x; ly = light_y; lz = light_z;
        d = lx * nx + ly * ny + lz * nz;
        nn = nx * nx + ny * ny + nz * nz;
        ll = lx * lx + ly * ly + lz * lz;
        nl = floor_sqrt(nn * ll);
        rx = reflect_q25(2 * d * nx - lx * 268435456);
        ry = reflect_q25(2 * d * ny - ly * 268435456);
        rz = reflect_q25(2 * d * nz - lz * 268435456);
        rlen = floor_sqrt(64'(rx * rx) + 64'(ry * ry) + 64'(rz * rz));
        diff = cosine_q16(d, nl);
        spec = cosine_q16(-rz, rlen);
        a = (spec < 0) ? -spec : spec;
        a2 = (a * a) >> 16;
        a4 = (a2 * a2) >> 16;
        s5 = longint'((a4 * a) >> 16);
        if (spec < 0)
            s5 = -s5;
        r = 214748365 + 45875 * diff + 32768 * s5;
        gb = 214748365 + 32768 * s5;
        c.red = channel12(r);
        c.green = channel12(gb);
        c.blue = channel12(gb);
        return c;
    endfunction

    task automatic idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        repeat (pick < 84 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
    endtask

    task automatic send_normal(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic signed [15:0] z, input bit with_gaps);
        normal_valid <= 1'b1;
        normal_x <= x;
        normal_y <= y;
        normal_z <= z;
        expected_colors = {expected_colors, shade(x, y, z)};
        do
            @(posedge clk);
        while (normal_stall);
        if (with_gaps && $urandom_range(0, 1))
        begin
            normal_valid <= 1'b0;
            idle_gap();
        end
    endtask

    task automatic end_stream();
        normal_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_light(input plu_pkg::cfg_idx_t idx, input logic signed [15:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(4 * idx);
        pwdata <= {{16{v[15]}}, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            plu_pkg::REG_LIGHT_X: light_x = v;
            plu_pkg::REG_LIGHT_Y: light_y = v;
            default:              light_z = v;
        endcase
    endtask

    task automatic set_light(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
        write_light(plu_pkg::REG_LIGHT_X, x);
        write_light(plu_pkg::REG_LIGHT_Y, y);
        write_light(plu_pkg::REG_LIGHT_Z, z);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_component();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'sh7FFF;
            2: return 16'sh8000;
            3: return 16'($urandom_range(0, 3)) - 16'sd1;
            default: return 16'($signed(16'($urandom_range(0, 32768))) - 16'sd16384);
        endcase
    endfunction

    task automatic test_directed();
        send_normal(16'sd0, 16'sd0, 16'sd0, 0);          // zero-length normal
        send_normal(16'sd0, 16'sd0, -16'sd16384, 0);
        send_normal(16'sd9459, 16'sd9459, -16'sd9459, 0); // along the light
        send_normal(-16'sd9459, -16'sd9459, 16'sd9459, 0);
        send_normal(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
        send_normal(16'sh8000, 16'sh8000, 16'sh8000, 0);
        send_normal(16'sh7FFF, 16'sh8000, 16'sh7FFF, 0);
        send_normal(16'sh8000, 16'sh7FFF, 16'sh8000, 0);
        send_normal(16'sd1, 16'sd0, 16'sd0, 0);
        send_normal(16'sd0, -16'sd1, 16'sd0, 0);
        send_normal(16'sd16384, 16'sd0, 16'sd0, 0);
        send_normal(16'sd0, 16'sd16384, 16'sd0, 0);
        send_normal(16'sd0, 16'sd0, 16'sd16384, 0);
        send_normal(16'sd0, 16'sd0, 16'sd1, 0);
        end_stream();
        drain();
        // zero light: every cosine collapses to zero
        set_light(16'sd0, 16'sd0, 16'sd0);
        send_normal(16'sd100, 16'sd200, -16'sd300, 0);
        send_normal(16'sd0, 16'sd0, 16'sd0, 0);
        // light straight on from the viewer
        end_stream();
        drain();
        set_light(16'sd0, 16'sd0, -16'sd16384);
        send_normal(16'sd0, 16'sd0, -16'sd16384, 0);
        send_normal(16'sd0, 16'sd0, 16'sd16384, 0);
        send_normal(16'sd16384, 16'sd0, 16'sd0, 0);
        end_stream();
        drain();
    endtask

    task automatic test_random(input int n);
        repeat (n)
            send_normal(rand_component(), rand_component(), rand_component(), 1);
        end_stream();
        drain();
    endtask

    task automatic test_light_settings();
        set_light(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        test_random(150);
        set_light(16'sh8000, 16'sh8000, 16'sh8000);
        test_random(150);
        set_light(16'sh8000, 16'sh7FFF, 16'sd0);
        test_random(150);
        set_light(rand_component(), rand_component(), rand_component());
        test_random(150);
        set_light(16'sd9459, 16'sd9459, -16'sd9459);
    endtask

    // Receiver holds off for a long stretch while the sender keeps sending.
    task automatic test_backpressure();
        hold_off = 200;
        repeat (150)
            send_normal(rand_component(), rand_component(), rand_component(), 0);
        end_stream();
        drain();
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        rgb_t want;
        if (rst_n && color_valid && !color_stall)
        begin
            if (expected_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected color %0d %0d %0d", red, green, blue);
            end
            else
            begin
                want = expected_colors.pop_front();
                if (want.red !== red || want.green !== green || want.blue !== blue)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("color mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                 want.red, want.green, want.blue, red, green, blue);
                end
            end
        end
    end

    // Receiver stall generator; a long hold-off is counted down here.
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            color_stall <= 1'b1;
        end
        else if (cycles % 2000 < 400)
            color_stall <= 1'b0;
        else
            color_stall <= ($urandom_range(0, 99) < ($urandom_range(0, 9) == 0 ? 90 : 25));
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600);
        test_light_settings();
        test_backpressure();
        test_random(600);
        if (mismatches == 0 && expected_colors.size() == 0)
            $display("[phong_lighting_unit_core] OK");
        else
            $display("[phong_lighting_unit_core] ERROR");
        $finish;
    end

endmodule
